### rtl/core/tqsf_pkg.sv
// ----------------------------------------------------------------------------
// tqsf_pkg
// Shared types and constants for the tcp queue steering filter.
// ----------------------------------------------------------------------------
package tqsf_pkg;

  localparam int unsigned NUM_QUEUES  = 64;
  localparam int unsigned QUEUE_W     = 6;
  localparam int unsigned MAP_W       = 64;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [COUNT_W-1:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [COUNT_W-1:0] IPV4_MIN_LEN   = 16'd20;
  localparam logic [COUNT_W-1:0] TCP_MIN_LEN    = 16'd20;
  localparam logic [COUNT_W-1:0] OFF_TYPE_HI    = 16'd12;
  localparam logic [COUNT_W-1:0] OFF_TYPE_LO    = 16'd13;
  localparam logic [COUNT_W-1:0] OFF_IHL        = 16'd14;
  localparam logic [COUNT_W-1:0] OFF_PROTO      = 16'd23;
  localparam logic [COUNT_W-1:0] OFF_PORT_MIN   = 16'd15;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [15:0]        ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]         PROTO_TCP      = 8'd6;
  localparam logic [3:0]         IHL_MIN        = 4'd5;
  localparam logic [PORT_W-1:0]  PORT_RESET     = 16'd22;

  localparam logic [CFG_INDEX_W-1:0] CFG_SOCKET_MAP   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALLOWED_PORT = 8'd1;

  typedef enum logic [1:0] {
    VERDICT_DROP     = 2'd0,
    VERDICT_PASS     = 2'd1,
    VERDICT_REDIRECT = 2'd2
  } verdict_t;

  // view of the frame headers including the byte being accepted
  typedef struct packed {
    logic [COUNT_W-1:0] len;
    logic [15:0]        ether_type;
    logic [3:0]         header_words;
    logic [7:0]         ip_proto;
    logic [PORT_W-1:0]  dest_port;
    logic [QUEUE_W-1:0] held_queue;
  } frame_info_t;

endpackage

### rtl/core/tcp_queue_steering_filter.sv
// ----------------------------------------------------------------------------
// tcp_queue_steering_filter
// Per-frame drop / pass / redirect verdict for a byte-wide ethernet stream.
// ----------------------------------------------------------------------------
// The input stream carries one frame byte per transaction: in_tdata is the
// byte, in_tlast marks the final byte and in_tuser the receive queue, which is
// used from the first byte of each frame. One result transaction leaves on
// out_* for every final byte and none for any other byte.
// A new byte is taken every cycle while out_* is not stalled; a frame's
// verdict appears on out_* in the cycle after its final byte is accepted.
// Header capture is a single pass per byte: one byte per clock unless stalled.
// The output holds one result. While it is held under a stall, in_tready
// stays high only if out_tready is high, so input stalls with the output.
// Register writes on cfg_* are always taken, one per cycle, and should be
// made while no frame is in flight. Index 0 is the socket bitmap, index 1 the
// allowed tcp port; other indexes are ignored.
// Reset clears the frame offset and the captured headers, empties the output
// register, clears the bitmap and sets the allowed port to 22.
// ----------------------------------------------------------------------------
module tcp_queue_steering_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [7:0] frame_byte
  input  logic                              in_tlast,
  input  logic [tqsf_pkg::QUEUE_W-1:0]      in_tuser,  // [5:0] rx_queue
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata, // [1:0] verdict, [7:2] target_queue
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tqsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [63:0]                       cfg_data
);
  import tqsf_pkg::*;

  logic [MAP_W-1:0]   socket_map_r;
  logic [PORT_W-1:0]  allowed_port_r;
  logic               in_accept;
  frame_info_t        info;
  verdict_t           verdict;
  logic [QUEUE_W-1:0] target_queue;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_tvalid || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      socket_map_r   <= '0;
      allowed_port_r <= PORT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SOCKET_MAP:   socket_map_r   <= cfg_data[MAP_W-1:0];
        CFG_ALLOWED_PORT: allowed_port_r <= cfg_data[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  tqsf_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .frame_byte (in_tdata),
    .last_byte  (in_tlast),
    .rx_queue   (in_tuser),
    .info       (info)
  );

  tqsf_verdict u_verdict (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_accept && in_tlast),
    .info         (info),
    .socket_map   (socket_map_r),
    .allowed_port (allowed_port_r),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .verdict      (verdict),
    .target_queue (target_queue)
  );

  assign out_tdata = {target_queue, verdict};

endmodule

### rtl/core/tqsf_parser.sv
// ----------------------------------------------------------------------------
// tqsf_parser
// Tracks the byte offset of the current frame and captures header fields.
// ----------------------------------------------------------------------------
module tqsf_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_accept,
  input  logic [7:0]                 frame_byte,
  input  logic                       last_byte,
  input  logic [tqsf_pkg::QUEUE_W-1:0] rx_queue,
  output tqsf_pkg::frame_info_t      info
);
  import tqsf_pkg::*;

  logic [COUNT_W-1:0] byte_count_r;
  logic [15:0]        ether_type_r;
  logic [3:0]         header_words_r;
  logic [7:0]         ip_proto_r;
  logic [PORT_W-1:0]  dest_port_r;
  logic [QUEUE_W-1:0] held_queue_r;

  logic [COUNT_W-1:0] tcp_off;
  logic [COUNT_W-1:0] len_nxt;
  logic [15:0]        ether_type_nxt;
  logic [3:0]         header_words_nxt;
  logic [7:0]         ip_proto_nxt;
  logic [PORT_W-1:0]  dest_port_nxt;
  logic [QUEUE_W-1:0] held_queue_nxt;

  always_comb begin
    tcp_off          = ETH_HDR_LEN + {10'd0, header_words_r, 2'b00};
    len_nxt          = (byte_count_r == COUNT_MAX) ? COUNT_MAX : byte_count_r + 16'd1;
    ether_type_nxt   = ether_type_r;
    header_words_nxt = header_words_r;
    ip_proto_nxt     = ip_proto_r;
    dest_port_nxt    = dest_port_r;
    held_queue_nxt   = held_queue_r;
    if (byte_count_r == '0) begin
      held_queue_nxt = rx_queue;
    end
    if (byte_count_r == OFF_TYPE_HI) begin
      ether_type_nxt[15:8] = frame_byte;
    end
    if (byte_count_r == OFF_TYPE_LO) begin
      ether_type_nxt[7:0] = frame_byte;
    end
    if (byte_count_r == OFF_IHL) begin
      header_words_nxt = frame_byte[3:0];
    end
    if (byte_count_r == OFF_PROTO) begin
      ip_proto_nxt = frame_byte;
    end
    // port sits two and three bytes into the tcp header
    if (byte_count_r >= OFF_PORT_MIN && byte_count_r == tcp_off + 16'd2) begin
      dest_port_nxt[15:8] = frame_byte;
    end
    if (byte_count_r >= OFF_PORT_MIN && byte_count_r == tcp_off + 16'd3) begin
      dest_port_nxt[7:0] = frame_byte;
    end
  end

  assign info = '{
    len:          len_nxt,
    ether_type:   ether_type_nxt,
    header_words: header_words_nxt,
    ip_proto:     ip_proto_nxt,
    dest_port:    dest_port_nxt,
    held_queue:   held_queue_nxt
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      ether_type_r   <= '0;
      header_words_r <= '0;
      ip_proto_r     <= '0;
      dest_port_r    <= '0;
      held_queue_r   <= '0;
    end else if (in_accept) begin
      if (last_byte) begin
        byte_count_r   <= '0;
        ether_type_r   <= '0;
        header_words_r <= '0;
        ip_proto_r     <= '0;
        dest_port_r    <= '0;
        held_queue_r   <= '0;
      end else begin
        byte_count_r   <= len_nxt;
        ether_type_r   <= ether_type_nxt;
        header_words_r <= header_words_nxt;
        ip_proto_r     <= ip_proto_nxt;
        dest_port_r    <= dest_port_nxt;
        held_queue_r   <= held_queue_nxt;
      end
    end
  end

  a_restart_after_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_accept && last_byte |=> byte_count_r == '0
  ) else $error("offset not cleared after final byte");

  a_count_advances: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_accept && !last_byte && byte_count_r != COUNT_MAX
      |=> byte_count_r == $past(byte_count_r) + 16'd1
  ) else $error("offset did not advance by one");

endmodule

### rtl/core/tqsf_verdict.sv
// ----------------------------------------------------------------------------
// tqsf_verdict
// Checks the captured headers on the final byte and registers the verdict.
// ----------------------------------------------------------------------------
module tqsf_verdict (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  tqsf_pkg::frame_info_t         info,
  input  logic [tqsf_pkg::MAP_W-1:0]    socket_map,
  input  logic [tqsf_pkg::PORT_W-1:0]   allowed_port,
  input  logic                          out_ready,
  output logic                          out_valid,
  output tqsf_pkg::verdict_t            verdict,
  output logic [tqsf_pkg::QUEUE_W-1:0]  target_queue
);
  import tqsf_pkg::*;

  logic               out_valid_r;
  verdict_t           verdict_r;
  logic [QUEUE_W-1:0] target_r;
  verdict_t           verdict_nxt;
  logic [QUEUE_W-1:0] target_nxt;
  logic [COUNT_W-1:0] tcp_end;
  logic               bound;

  always_comb begin
    tcp_end     = ETH_HDR_LEN + TCP_MIN_LEN + {10'd0, info.header_words, 2'b00};
    bound       = ({1'b0, info.held_queue} < 7'(NUM_QUEUES))
                  && socket_map[info.held_queue];
    verdict_nxt = VERDICT_DROP;
    target_nxt  = '0;
    if (info.len < ETH_HDR_LEN
        || info.ether_type != ETHERTYPE_IPV4
        || info.len < ETH_HDR_LEN + IPV4_MIN_LEN
        || info.ip_proto != PROTO_TCP
        || info.header_words < IHL_MIN
        || info.len < tcp_end) begin
      verdict_nxt = VERDICT_DROP;
    end else if (info.dest_port == allowed_port) begin
      verdict_nxt = VERDICT_PASS;
    end else if (bound) begin
      verdict_nxt = VERDICT_REDIRECT;
      target_nxt  = info.held_queue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= verdict_nxt;
      target_r  <= target_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign verdict      = verdict_r;
  assign target_queue = target_r;

  a_redirect_bound: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == VERDICT_REDIRECT |-> socket_map[target_r]
  ) else $error("redirect to a queue with no socket");

  a_target_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r != VERDICT_REDIRECT |-> target_r == '0
  ) else $error("target queue set without redirect");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Frame-level check of the tcp queue steering filter: byte streams built as
// tcp/ipv4 frames, broken frames and noise are fed in, and every verdict is
// compared against a behavioral predictor under several register settings
// and mixes of input idling and output stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tqsf_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'hFF;
  localparam int unsigned PHASE_BYTES    = 190;
  localparam int unsigned PHASE_FRAMES   = 3;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

  typedef struct {
    verdict_t           verdict;
    logic [QUEUE_W-1:0] target;
  } verdict_rec_t;

  class steering_scoreboard;
    logic [MAP_W-1:0]   socket_map;
    logic [PORT_W-1:0]  allowed_port;
    logic [COUNT_W-1:0] offset;
    logic [15:0]        ether_type;
    logic [3:0]         ihl;
    logic [7:0]         proto;
    logic [PORT_W-1:0]  dest_port;
    logic [QUEUE_W-1:0] frame_queue;
    verdict_rec_t       verdicts[$];
    int unsigned        errors, bytes_seen, frames_seen, n_pass, n_redirect, n_drop;

    function new();
      socket_map   = '0;
      allowed_port = PORT_RESET;
      errors       = 0;
      bytes_seen   = 0;
      frames_seen  = 0;
      n_pass       = 0;
      n_redirect   = 0;
      n_drop       = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset      = '0;
      ether_type  = '0;
      ihl         = '0;
      proto       = '0;
      dest_port   = '0;
      frame_queue = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [63:0] data);
      if (index == CFG_SOCKET_MAP) begin
        socket_map = data;
      end else if (index == CFG_ALLOWED_PORT) begin
        allowed_port = data[PORT_W-1:0];
      end
    endfunction

    function verdict_rec_t judge(int unsigned len);
      verdict_rec_t r;
      int unsigned  tcp_end;
      r.verdict = VERDICT_DROP;
      r.target  = '0;
      tcp_end   = ETH_HDR_LEN + 4 * ihl + TCP_MIN_LEN;
      if (len < ETH_HDR_LEN || ether_type != ETHERTYPE_IPV4 ||
          len < ETH_HDR_LEN + IPV4_MIN_LEN || proto != PROTO_TCP ||
          ihl < IHL_MIN || len < tcp_end) begin
        return r;
      end
      if (dest_port == allowed_port) begin
        r.verdict = VERDICT_PASS;
      end else if (socket_map[frame_queue]) begin
        r.verdict = VERDICT_REDIRECT;
        r.target  = frame_queue;
      end
      return r;
    endfunction

    function void note_byte(logic [7:0] data_v, logic last_v, logic [QUEUE_W-1:0] queue_v);
      int unsigned  off, tcp_off, len;
      verdict_rec_t r;
      off     = offset;
      // port position uses the header length captured before this byte
      tcp_off = ETH_HDR_LEN + 4 * ihl;
      bytes_seen++;
      if (off == 0) frame_queue = queue_v;
      if (off == OFF_TYPE_HI) ether_type[15:8] = data_v;
      if (off == OFF_TYPE_LO) ether_type[7:0] = data_v;
      if (off == OFF_IHL) ihl = data_v[3:0];
      if (off == OFF_PROTO) proto = data_v;
      if (off >= OFF_PORT_MIN && off == tcp_off + 2) dest_port[15:8] = data_v;
      if (off >= OFF_PORT_MIN && off == tcp_off + 3) dest_port[7:0] = data_v;
      len    = (off >= COUNT_MAX) ? COUNT_MAX : off + 1;
      offset = len[COUNT_W-1:0];
      if (last_v) begin
        r = judge(len);
        verdicts.push_back(r);
        frames_seen++;
        case (r.verdict)
          VERDICT_PASS:     n_pass++;
          VERDICT_REDIRECT: n_redirect++;
          default:          n_drop++;
        endcase
        clear_frame();
      end
    endfunction

    function void check_verdict(logic [7:0] tdata);
      verdict_rec_t r;
      if (verdicts.size() == 0) begin
        $error("verdict transaction with none expected: tdata 0x%02h", tdata);
        errors++;
        return;
      end
      r = verdicts.pop_front();
      if (tdata[1:0] !== r.verdict) begin
        $error("verdict: expected %0d, actual %0d", r.verdict, tdata[1:0]);
        errors++;
      end
      if (tdata[7:2] !== r.target) begin
        $error("target_queue: expected %0d, actual %0d", r.target, tdata[7:2]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdicts.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;   // [7:0] frame_byte
  logic                   in_tlast;
  logic [QUEUE_W-1:0]     in_tuser;   // [5:0] rx_queue
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [7:0]             out_tdata;  // [1:0] verdict, [7:2] target_queue
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;

  steering_scoreboard sb = new();
  logic [7:0]  frame_q[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  tcp_queue_steering_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[tcp_queue_steering_filter] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata);
  end

  // random payload with the header fields placed where the filter looks
  function automatic void build_frame(int unsigned len, logic [15:0] etype, logic [3:0] ihl_v,
                                      logic [7:0] proto_v, logic [15:0] port_v);
    int unsigned port_off;
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
    port_off = 14 + 4 * ihl_v + 2;
    if (len > 12) frame_q[12] = etype[15:8];
    if (len > 13) frame_q[13] = etype[7:0];
    if (len > 14) frame_q[14] = {frame_q[14][7:4], ihl_v};
    if (len > 23) frame_q[23] = proto_v;
    if (len > port_off) frame_q[port_off] = port_v[15:8];
    if (len > port_off + 1) frame_q[port_off + 1] = port_v[7:0];
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] data_v, logic last_v, logic [QUEUE_W-1:0] queue_v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = data_v;
    in_tlast  = last_v;
    in_tuser  = queue_v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(data_v, last_v, queue_v);
    @(negedge clk);
  endtask

  task automatic send_frame(logic [QUEUE_W-1:0] rxq);
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1, (i == 0) ? rxq : QUEUE_W'($urandom));
    end
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [63:0] data);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_frame();
    int unsigned kind, ihl_v, min_len;
    logic [15:0] port_v;
    kind    = $urandom_range(0, 99);
    ihl_v   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    min_len = 14 + 4 * ihl_v + 20;
    port_v  = ($urandom_range(0, 2) == 0) ? sb.allowed_port : 16'($urandom);
    if (kind < 70) begin
      build_frame(min_len + $urandom_range(0, 16), ETHERTYPE_IPV4, 4'(ihl_v), PROTO_TCP, port_v);
    end else if (kind < 85) begin
      // well-formed frame with one fault
      case ($urandom_range(0, 3))
        0: build_frame($urandom_range(1, min_len - 1), ETHERTYPE_IPV4, 4'(ihl_v),
                       PROTO_TCP, port_v);
        1: build_frame(min_len, 16'($urandom), 4'(ihl_v), PROTO_TCP, port_v);
        2: build_frame(min_len, ETHERTYPE_IPV4, 4'(ihl_v), 8'($urandom), port_v);
        default: build_frame(min_len, ETHERTYPE_IPV4, 4'($urandom_range(0, 4)),
                             PROTO_TCP, port_v);
      endcase
    end else begin
      build_frame($urandom_range(1, 80), 16'($urandom), 4'($urandom), 8'($urandom),
                  16'($urandom));
    end
    send_frame(QUEUE_W'($urandom));
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                           logic [63:0] map, logic [15:0] port);
    int unsigned start_bytes, start_frames;
    wait_idle();
    write_register(CFG_SOCKET_MAP, map);
    write_register(CFG_ALLOWED_PORT, {48'($urandom), port});
    write_register(CFG_UNUSED_INDEX, {$urandom, $urandom});
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_bytes    = sb.bytes_seen;
    start_frames   = sb.frames_seen;
    while (sb.bytes_seen - start_bytes < PHASE_BYTES ||
           sb.frames_seen - start_frames < PHASE_FRAMES) begin
      send_random_frame();
      // occasionally hold off until every verdict is out
      if ($urandom_range(0, 24) == 0) wait_idle();
    end
  endtask

  initial begin
    int unsigned guard;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // registers at reset values: pass on the reset port, truncation and header faults
    build_frame(1, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80);
    send_frame(6'd0);
    build_frame(13, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, PORT_RESET);
    send_frame(6'd1);
    build_frame(14, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, PORT_RESET);
    send_frame(6'd2);
    build_frame(33, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, PORT_RESET);
    send_frame(6'd3);
    build_frame(54, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, PORT_RESET);
    send_frame(6'd4);
    build_frame(54, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80);
    send_frame(6'd0);
    build_frame(60, ETHERTYPE_IPV6, IHL_MIN, PROTO_TCP, PORT_RESET);
    send_frame(6'd5);
    build_frame(60, ETHERTYPE_IPV4, IHL_MIN, PROTO_UDP, PORT_RESET);
    send_frame(6'd6);
    build_frame(60, ETHERTYPE_IPV4, 4'd4, PROTO_TCP, PORT_RESET);
    send_frame(6'd7);
    build_frame(60, ETHERTYPE_IPV4, 4'd0, PROTO_TCP, PORT_RESET);
    send_frame(6'd8);

    // sockets on the lowest and highest queue
    wait_idle();
    write_register(CFG_SOCKET_MAP, 64'h8000_0000_0000_0001);
    write_register(CFG_UNUSED_INDEX, {$urandom, $urandom});
    build_frame(54, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80);
    send_frame(6'd0);
    build_frame(54, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80);
    send_frame(6'd63);
    build_frame(54, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd80);
    send_frame(6'd5);
    build_frame(94, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'd443);
    send_frame(6'd63);
    build_frame(93, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'd443);
    send_frame(6'd63);
    build_frame(57, ETHERTYPE_IPV4, 4'd6, PROTO_TCP, PORT_RESET);
    send_frame(6'd0);
    build_frame(58, ETHERTYPE_IPV4, 4'd6, PROTO_TCP, PORT_RESET);
    send_frame(6'd0);
    build_frame(54, ETHERTYPE_IPV4, IHL_MIN, PROTO_TCP, 16'hFFFF);
    send_frame(6'd0);

    run_phase(0, 0, '1, 16'hFFFF);
    run_phase(51, 0, '0, 16'h0000);
    run_phase(0, 51, {$urandom, $urandom}, 16'($urandom));
    run_phase(32, 32, 64'd1 << $urandom_range(0, 63), 16'($urandom));

    in_tvalid = 1'b0;
    guard     = 0;
    while (sb.pending() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending() > 0) begin
      $error("%0d verdicts never arrived", sb.pending());
      sb.errors++;
    end
    $display("covered %0d frames in %0d bytes: %0d passed, %0d redirected, %0d dropped",
             sb.frames_seen, sb.bytes_seen, sb.n_pass, sb.n_redirect, sb.n_drop);
    $display("reset registers plus five register sets, four idle/stall mixes");
    if (sb.errors == 0) begin
      $display("[tcp_queue_steering_filter] OK");
    end else begin
      $display("[tcp_queue_steering_filter] ERROR");
    end
    $finish;
  end

endmodule
